### hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define CHECK_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHECK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/gffvc_pkg.sv
// shared types and constants of the face velocity correction pipeline
package gffvc_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int KDIV_STEPS = 32;
   localparam int QDIV_STEPS = 95;

   // configuration register indexes
   localparam logic [0:0] CSR_SIGMA = 1'b0;
   localparam logic [0:0] CSR_DT    = 1'b1;

   localparam logic [16:0] COLOR_HALF = 17'd32768;
   localparam logic [31:0] VEL_MAX    = 32'h7fff_ffff;
   localparam logic [31:0] VEL_MIN    = 32'h8000_0000;

   // one face as it enters
   typedef struct packed {
      logic signed [31:0] velocity_old;
      logic signed [31:0] pressure_lower;
      logic signed [31:0] pressure_center;
      logic [16:0]        color_lower;
      logic [16:0]        color_center;
      logic signed [31:0] curvature_lower;
      logic signed [31:0] curvature_center;
      logic [30:0]        density;
      logic [30:0]        spacing;
      logic               face_active;
   } face_type;

   // what travels alongside the curvature and jump stages
   typedef struct packed {
      logic signed [31:0] vold;
      logic signed [31:0] pl;
      logic signed [31:0] pc;
      logic               active;
      logic               crossed;
      logic               col_neg;
      logic [61:0]        divisor;
   } base_type;

   // what travels alongside the long division
   typedef struct packed {
      logic signed [31:0] vold;
      logic               active;
      logic               crossed;
      logic               diff_neg;
   } tail_type;

   // one result
   typedef struct packed {
      logic [31:0] velocity_new;
      logic        interface_crossed;
      logic        saturated;
   } result_type;

endpackage

### hw/rtl/gffvc_kappa.sv
// crossing test, mean curvature and divisor product, with a pipelined harmonic mean divider
module gffvc_kappa
   import gffvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  face_type    in_face,
   output logic        out_valid,
   output base_type    out_base,
   output logic [31:0] out_kmag,
   output logic        out_kneg
);

   localparam int KS = KDIV_STEPS;

   logic [31:0]        kl_u, kc_u, a_w, b_w;
   logic               same_w;
   logic signed [32:0] ksum_w, ksum_adj_w, mean_w, mean_neg_w;
   logic [63:0]        prod_w;
   logic [30:0]        rho_w, dx_w;
   base_type           base_w;

   logic               valid_ff [0:KS];
   base_type           base_ff  [0:KS];
   logic               same_ff  [0:KS];
   logic               sgn_ff   [0:KS];
   logic [31:0]        mmag_ff  [0:KS];
   logic               mneg_ff  [0:KS];
   logic [32:0]        hd_ff    [0:KS];
   logic [32:0]        rem_ff   [0:KS];
   logic [31:0]        nlo_ff   [0:KS];
   logic [31:0]        q_ff     [0:KS];

   logic [33:0]        t_w      [1:KS];
   logic               ge_w     [1:KS];
   logic [33:0]        sub_w    [1:KS];
   logic [32:0]        rem_in   [1:KS];
   logic [31:0]        nlo_in   [1:KS];
   logic [31:0]        q_in     [1:KS];

   // front stage: magnitudes, crossing, arithmetic mean, products
   always_comb begin
      kl_u   = in_face.curvature_lower;
      kc_u   = in_face.curvature_center;
      a_w    = kl_u[31] ? (~kl_u + 32'd1) : kl_u;
      b_w    = kc_u[31] ? (~kc_u + 32'd1) : kc_u;
      same_w = (!kl_u[31] && (kl_u != 32'd0) && !kc_u[31] && (kc_u != 32'd0)) ||
               (kl_u[31] && kc_u[31]);
      ksum_w     = {kl_u[31], kl_u} + {kc_u[31], kc_u};
      ksum_adj_w = ksum_w + {32'd0, ksum_w[32] & ksum_w[0]};
      mean_w     = ksum_adj_w >>> 1;
      mean_neg_w = 33'd0 - mean_w;
      prod_w     = a_w * b_w;
      rho_w      = (in_face.density == 31'd0) ? 31'd1 : in_face.density;
      dx_w       = (in_face.spacing == 31'd0) ? 31'd1 : in_face.spacing;
      base_w.vold    = in_face.velocity_old;
      base_w.pl      = in_face.pressure_lower;
      base_w.pc      = in_face.pressure_center;
      base_w.active  = in_face.face_active;
      base_w.crossed = in_face.face_active &&
         (((in_face.color_lower < COLOR_HALF) && (in_face.color_center > COLOR_HALF)) ||
          ((in_face.color_lower > COLOR_HALF) && (in_face.color_center < COLOR_HALF)));
      base_w.col_neg = in_face.color_center < COLOR_HALF;
      base_w.divisor = rho_w * dx_w;
   end

   // one quotient bit per stage of 2ab / (a + b)
   always_comb begin
      for (int s = 1; s <= KS; s++) begin
         t_w[s]    = {rem_ff[s-1], nlo_ff[s-1][31]};
         ge_w[s]   = t_w[s] >= {1'b0, hd_ff[s-1]};
         sub_w[s]  = t_w[s] - {1'b0, hd_ff[s-1]};
         rem_in[s] = ge_w[s] ? sub_w[s][32:0] : t_w[s][32:0];
         nlo_in[s] = {nlo_ff[s-1][30:0], 1'b0};
         q_in[s]   = {q_ff[s-1][30:0], ge_w[s]};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= KS; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= KS; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // payload and divider state
   always_ff @(posedge clock) begin
      if (en) begin
         base_ff[0] <= base_w;
         same_ff[0] <= same_w;
         sgn_ff[0]  <= kl_u[31];
         mmag_ff[0] <= mean_w[32] ? mean_neg_w[31:0] : mean_w[31:0];
         mneg_ff[0] <= mean_w[32];
         hd_ff[0]   <= {1'b0, a_w} + {1'b0, b_w};
         rem_ff[0]  <= {1'b0, prod_w[62:31]};
         nlo_ff[0]  <= {prod_w[30:0], 1'b0};
         q_ff[0]    <= 32'd0;
         for (int s = 1; s <= KS; s++) begin
            base_ff[s] <= base_ff[s-1];
            same_ff[s] <= same_ff[s-1];
            sgn_ff[s]  <= sgn_ff[s-1];
            mmag_ff[s] <= mmag_ff[s-1];
            mneg_ff[s] <= mneg_ff[s-1];
            hd_ff[s]   <= hd_ff[s-1];
            rem_ff[s]  <= rem_in[s];
            nlo_ff[s]  <= nlo_in[s];
            q_ff[s]    <= q_in[s];
         end
      end
   end

   // harmonic mean when signs agree, else arithmetic mean
   assign out_valid = valid_ff[KS];
   assign out_base  = base_ff[KS];
   assign out_kmag  = same_ff[KS] ? q_ff[KS] : mmag_ff[KS];
   assign out_kneg  = same_ff[KS] ? sgn_ff[KS] : mneg_ff[KS];

endmodule

### hw/rtl/gffvc_flux.sv
// pressure jump, pressure difference and dividend product stages
module gffvc_flux
   import gffvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [30:0] sigma,
   input  logic [30:0] dt,
   input  logic        in_valid,
   input  base_type    in_base,
   input  logic [31:0] in_kmag,
   input  logic        in_kneg,
   output logic        out_valid,
   output tail_type    out_tail,
   output logic [61:0] out_divisor,
   output logic [94:0] out_num
);

   logic [4:0]  valid_ff;
   base_type    base0_ff, base1_ff;
   logic [62:0] jp0_ff;
   logic        neg0_ff;
   logic [47:0] pladj1_ff;
   tail_type    tail2_ff, tail3_ff, tail4_ff;
   logic [61:0] div2_ff, div3_ff, div4_ff;
   logic [47:0] dmag2_ff;
   logic [62:0] plo3_ff;
   logic [46:0] phi3_ff;
   logic [94:0] num4_ff;

   logic [47:0] pl48_w, jm48_w, pladj_w;
   logic [48:0] diff_w, ndiff_w;
   logic [78:0] prod_w;
   tail_type    tail_w;

   // jump added to or taken from the lower pressure at a crossing, then the difference
   always_comb begin
      pl48_w  = {{16{base0_ff.pl[31]}}, base0_ff.pl};
      jm48_w  = {2'b00, jp0_ff[61:16]};
      if (!base0_ff.crossed) begin
         pladj_w = pl48_w;
      end else if (neg0_ff) begin
         pladj_w = pl48_w - jm48_w;
      end else begin
         pladj_w = pl48_w + jm48_w;
      end
      diff_w  = {pladj1_ff[47], pladj1_ff} - {{17{base1_ff.pc[31]}}, base1_ff.pc};
      ndiff_w = 49'd0 - diff_w;
      tail_w.vold     = base1_ff.vold;
      tail_w.active   = base1_ff.active;
      tail_w.crossed  = base1_ff.crossed;
      tail_w.diff_neg = diff_w[48];
      prod_w  = {16'd0, plo3_ff} + {phi3_ff, 32'd0};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 5'd0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (en) begin
         base0_ff  <= in_base;
         jp0_ff    <= sigma * in_kmag;
         neg0_ff   <= in_kneg != in_base.col_neg;
         base1_ff  <= base0_ff;
         pladj1_ff <= pladj_w;
         tail2_ff  <= tail_w;
         div2_ff   <= base1_ff.divisor;
         dmag2_ff  <= diff_w[48] ? ndiff_w[47:0] : diff_w[47:0];
         tail3_ff  <= tail2_ff;
         div3_ff   <= div2_ff;
         plo3_ff   <= dmag2_ff[31:0] * dt;
         phi3_ff   <= dmag2_ff[47:32] * dt;
         tail4_ff  <= tail3_ff;
         div4_ff   <= div3_ff;
         num4_ff   <= {prod_w, 16'd0};
      end
   end

   assign out_valid   = valid_ff[4];
   assign out_tail    = tail4_ff;
   assign out_divisor = div4_ff;
   assign out_num     = num4_ff;

endmodule

### hw/rtl/gffvc_quot.sv
// pipelined restoring divider of the velocity increment, quotient capped at 2^62
module gffvc_quot
   import gffvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  tail_type    in_tail,
   input  logic [61:0] in_divisor,
   input  logic [94:0] in_num,
   output logic        out_valid,
   output tail_type    out_tail,
   output logic [62:0] out_quot
);

   localparam int QS = QDIV_STEPS;

   logic        valid_ff [0:QS];
   tail_type    tail_ff  [0:QS];
   logic [61:0] d_ff     [0:QS];
   logic [61:0] rem_ff   [0:QS];
   logic [94:0] nb_ff    [0:QS];
   logic [61:0] q_ff     [0:QS];
   logic        big_ff   [0:QS];

   logic [62:0] t_w    [1:QS];
   logic [62:0] sub_w  [1:QS];
   logic        ge_w   [1:QS];
   logic [62:0] newq_w [1:QS];

   // one quotient bit per stage
   always_comb begin
      for (int s = 1; s <= QS; s++) begin
         t_w[s]    = {rem_ff[s-1], nb_ff[s-1][94]};
         ge_w[s]   = t_w[s] >= {1'b0, d_ff[s-1]};
         sub_w[s]  = t_w[s] - {1'b0, d_ff[s-1]};
         newq_w[s] = {q_ff[s-1], ge_w[s]};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QS; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= QS; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // divider state and payload
   always_ff @(posedge clock) begin
      if (en) begin
         tail_ff[0] <= in_tail;
         d_ff[0]    <= in_divisor;
         rem_ff[0]  <= 62'd0;
         nb_ff[0]   <= in_num;
         q_ff[0]    <= 62'd0;
         big_ff[0]  <= 1'b0;
         for (int s = 1; s <= QS; s++) begin
            tail_ff[s] <= tail_ff[s-1];
            d_ff[s]    <= d_ff[s-1];
            rem_ff[s]  <= ge_w[s] ? sub_w[s][61:0] : t_w[s][61:0];
            nb_ff[s]   <= {nb_ff[s-1][93:0], 1'b0};
            q_ff[s]    <= newq_w[s][61:0];
            big_ff[s]  <= big_ff[s-1] | newq_w[s][62];
         end
      end
   end

   assign out_valid = valid_ff[QS];
   assign out_tail  = tail_ff[QS];
   assign out_quot  = big_ff[QS] ? {1'b1, 62'd0} : {1'b0, q_ff[QS]};

endmodule

### hw/rtl/ghost_fluid_face_velocity_correction_top.sv
// top level of the ghost fluid face velocity correction pipeline
// Takes one velocity face per clock and returns one corrected velocity per face, in order.
// It has 33 stages for the crossing test and the 32 bit harmonic mean divider, 5 for the
// pressure jump and the increment dividend, 96 for the restoring divider of the increment
// (one quotient bit per stage) and one output buffer stage. The throughput is one face per
// cycle; the pipeline holds only when the two-entry output buffer is full. The csr port
// takes configuration, written only while no face is in flight: a user rule, unenforced.
`include "assert_macros.svh"

module ghost_fluid_face_velocity_correction_top
   import gffvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input faces
   input  logic         req_tvalid,
   output logic         req_tready,
   // velocity_old, pressure_lower, pressure_center, color_lower, color_center,
   // curvature_lower, curvature_center, density, spacing
   input  logic [255:0] req_tdata,
   // face_active
   input  logic [0:0]   req_tuser,
   // corrected velocities
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // velocity_new
   output logic [31:0]  rsp_tdata,
   // interface_crossed, saturated
   output logic [1:0]   rsp_tuser,
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic [30:0] sigma_ff, dt_ff;
   logic        en;
   face_type    face_w;

   logic        k_valid;
   base_type    k_base;
   logic [31:0] k_kmag;
   logic        k_kneg;

   logic        f_valid;
   tail_type    f_tail;
   logic [61:0] f_div;
   logic [94:0] f_num;

   logic        q_valid;
   tail_type    q_tail;
   logic [62:0] q_quot;

   logic [64:0] v65_w, q65_w, sum_w;
   logic        sat_hi_w, sat_lo_w;
   result_type  res_w;

   logic [1:0]  skid_cnt_ff;
   result_type  slot0_ff, slot1_ff;
   logic        skid_push, skid_pop;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= 31'd0;
         dt_ff    <= 31'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SIGMA: sigma_ff <= csr_data[30:0];
            CSR_DT:    dt_ff    <= csr_data[30:0];
            default:   ;
         endcase
      end
   end

   // unpack the input transaction
   always_comb begin
      face_w.velocity_old     = req_tdata[31:0];
      face_w.pressure_lower   = req_tdata[63:32];
      face_w.pressure_center  = req_tdata[95:64];
      face_w.color_lower      = req_tdata[112:96];
      face_w.color_center     = req_tdata[129:113];
      face_w.curvature_lower  = req_tdata[161:130];
      face_w.curvature_center = req_tdata[193:162];
      face_w.density          = req_tdata[224:194];
      face_w.spacing          = req_tdata[255:225];
      face_w.face_active      = req_tuser[0];
   end

   // whole pipeline advances while the output buffer has room
   assign en         = skid_cnt_ff != 2'd2;
   assign req_tready = en;

   gffvc_kappa u_kappa (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_face   (face_w),
      .out_valid (k_valid),
      .out_base  (k_base),
      .out_kmag  (k_kmag),
      .out_kneg  (k_kneg)
   );

   gffvc_flux u_flux (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .sigma       (sigma_ff),
      .dt          (dt_ff),
      .in_valid    (k_valid),
      .in_base     (k_base),
      .in_kmag     (k_kmag),
      .in_kneg     (k_kneg),
      .out_valid   (f_valid),
      .out_tail    (f_tail),
      .out_divisor (f_div),
      .out_num     (f_num)
   );

   gffvc_quot u_quot (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (f_valid),
      .in_tail    (f_tail),
      .in_divisor (f_div),
      .in_num     (f_num),
      .out_valid  (q_valid),
      .out_tail   (q_tail),
      .out_quot   (q_quot)
   );

   // final add and saturation
   always_comb begin
      v65_w    = {{33{q_tail.vold[31]}}, q_tail.vold};
      q65_w    = {2'b00, q_quot};
      sum_w    = q_tail.diff_neg ? (v65_w - q65_w) : (v65_w + q65_w);
      sat_hi_w = !sum_w[64] && (sum_w[63:31] != 33'd0);
      sat_lo_w = sum_w[64] && (sum_w[63:31] != {33{1'b1}});
      if (!q_tail.active) begin
         res_w.velocity_new = q_tail.vold;
         res_w.saturated    = 1'b0;
      end else if (sat_hi_w) begin
         res_w.velocity_new = VEL_MAX;
         res_w.saturated    = 1'b1;
      end else if (sat_lo_w) begin
         res_w.velocity_new = VEL_MIN;
         res_w.saturated    = 1'b1;
      end else begin
         res_w.velocity_new = sum_w[31:0];
         res_w.saturated    = 1'b0;
      end
      res_w.interface_crossed = q_tail.crossed;
   end

   // two-entry output buffer
   assign skid_push = en && q_valid;
   assign skid_pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_cnt_ff <= 2'd0;
      end else if (skid_push && !skid_pop) begin
         skid_cnt_ff <= skid_cnt_ff + 2'd1;
      end else if (skid_pop && !skid_push) begin
         skid_cnt_ff <= skid_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_push && skid_pop) begin
         slot0_ff <= res_w;
      end else if (skid_push) begin
         if (skid_cnt_ff == 2'd0) begin
            slot0_ff <= res_w;
         end else begin
            slot1_ff <= res_w;
         end
      end else if (skid_pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_tvalid = skid_cnt_ff != 2'd0;
   assign rsp_tdata  = slot0_ff.velocity_new;
   assign rsp_tuser  = {slot0_ff.saturated, slot0_ff.interface_crossed};

   `CHECK_ALWAYS(a_cnt_legal, skid_cnt_ff != 2'd3, "output buffer count out of range")
   `CHECK_IMPLY(a_push_room, skid_push, skid_cnt_ff != 2'd2, "push into a full output buffer")
   `CHECK_NEXT(a_cnt_step, skid_cnt_ff == 2'd0, skid_cnt_ff != 2'd2, "output buffer jumped by two")
   `CHECK_IMPLY(a_sat_value, rsp_tvalid && rsp_tuser[1], rsp_tdata == VEL_MAX || rsp_tdata == VEL_MIN, "saturated flag without a clipped velocity")

endmodule
